// ----- rtl/core/pcot_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pcot_pkg;

   // Fixed field widths of the request and response words.
   localparam int MEMBER_FIELDS = 5;
   localparam int MEMBER_W      = 7;
   localparam int SIZE_W        = 3;
   localparam int REM_W         = 11;

   // Scan cursor width: covers up to 128 rows plus one chunk of columns.
   localparam int CNT_W         = 8;

   // Columns examined per cycle by the fetch scanner.
   localparam int CHUNK         = 8;
   localparam int OFF_W         = 3;

   localparam logic MODE_MARK   = 1'b0;
   localparam logic MODE_FETCH  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_FETCH_RD,
      ST_FETCH_LD,
      ST_FETCH_SCAN,
      ST_FINISH
   } pcot_state_type;

   typedef struct packed {
      logic bad;
      logic clear;
      logic hit;
   } pcot_lane_stat_type;

endpackage

`default_nettype wire

// ----- rtl/core/pcot_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pcot_req_if
   import pcot_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                mode;
   logic [SIZE_W-1:0]   set_size;
   logic [MEMBER_W-1:0] member_a;
   logic [MEMBER_W-1:0] member_b;
   logic [MEMBER_W-1:0] member_c;
   logic [MEMBER_W-1:0] member_d;
   logic [MEMBER_W-1:0] member_e;

   modport source (
      output valid, mode, set_size, member_a, member_b, member_c, member_d, member_e,
      input  ready
   );

   modport sink (
      input  valid, mode, set_size, member_a, member_b, member_c, member_d, member_e,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/core/pcot_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pcot_rsp_if
   import pcot_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [REM_W-1:0]    remaining;
   logic                pair_valid;
   logic [MEMBER_W-1:0] pair_high;
   logic [MEMBER_W-1:0] pair_low;
   logic                range_error;

   modport source (
      output valid, remaining, pair_valid, pair_high, pair_low, range_error,
      input  ready
   );

   modport sink (
      input  valid, remaining, pair_valid, pair_high, pair_low, range_error,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/core/pcot_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pcot_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/pcot_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pcot_lane
   import pcot_pkg::*;
#(
   parameter int ROWS = 64
) (
   input  wire logic [MEMBER_W-1:0] member,
   input  wire logic                enable,
   input  wire logic                dup,
   input  wire logic [MEMBER_W-1:0] cur_member,
   input  wire logic [MEMBER_W-1:0] num_items,
   input  wire logic [ROWS-1:0]     row_word,
   output pcot_lane_stat_type       stat,
   output logic      [ROWS-1:0]     mask
);

   logic [MEMBER_W-1:0] col;

   assign col = member - MEMBER_W'(1);

   always_comb begin
      stat.bad   = enable && ((member == '0) || (member > num_items));
      stat.clear = enable && (member < cur_member);
      for (int i = 0; i < ROWS; i++) begin
         mask[i] = stat.clear && (col == MEMBER_W'(i));
      end
      // A repeated member clears the same bit, so only its first lane counts it.
      stat.hit = (|(mask & row_word)) && !dup;
   end

endmodule

`default_nettype wire

// ----- rtl/core/pcot_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pcot_scan
   import pcot_pkg::*;
#(
   parameter int ROWS = 64
) (
   input  wire logic [ROWS-1:0]  row_word,
   input  wire logic [CNT_W-1:0] row,
   input  wire logic [CNT_W-1:0] col,
   output logic                  found,
   output logic      [OFF_W-1:0] offset
);

   logic [ROWS+CHUNK-1:0] word_ext;
   logic [CHUNK-1:0]      cand;

   always_comb begin
      word_ext = {{CHUNK{1'b0}}, row_word} >> col;
      for (int i = 0; i < CHUNK; i++) begin
         cand[i] = word_ext[i] && ((col + CNT_W'(i)) < row);
      end
      found  = |cand;
      offset = '0;
      for (int i = CHUNK - 1; i >= 0; i--) begin
         if (cand[i]) begin
            offset = OFF_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/pair_cooccurrence_tracker_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// A mark checks its members, then reads and writes back the row of each member in turn, and
// finishes; a bad member goes straight to finish. A fetch reads, loads and scans each row from
// the cursor on, a chunk of columns at a time, until it finds an open pair or runs out of rows.
// One word is in flight at a time; the next word is accepted in the cycle after the response
// is loaded, even while that response waits.
// Reset (synchronous) sets num_items to MAX_ITEMS capped at 64, reloads the pair count, rewinds
// the cursor and clears all row-valid bits, so every row reads as its untouched lower triangle at once.

module pair_cooccurrence_tracker_top
   import pcot_pkg::*;
#(
   parameter int MAX_ITEMS = 64,
   parameter int SET_SLOTS = 5
) (
   input  wire logic                clock,
   input  wire logic                reset,
   pcot_req_if.sink                 req_chan,
   pcot_rsp_if.source               rsp_chan,
   input  wire logic                csr_write_en,
   input  wire logic [MEMBER_W-1:0] csr_write_data
);

   localparam int ROWS    = (MAX_ITEMS < 128) ? MAX_ITEMS : 128;
   localparam int RW      = $clog2(ROWS);
   localparam int SLOTS   = (SET_SLOTS < MEMBER_FIELDS) ? SET_SLOTS : MEMBER_FIELDS;
   localparam int NUM_RST = (MAX_ITEMS < 64) ? MAX_ITEMS : 64;
   localparam int CNT_RST = (NUM_RST * (NUM_RST - 1) / 2) % (1 << REM_W);

   pcot_state_type state_ff, state_in;

   logic [MEMBER_W-1:0] num_ff;
   logic [REM_W-1:0]    count_ff;
   logic [CNT_W-1:0]    scan_row_ff;
   logic [CNT_W-1:0]    scan_col_ff;
   logic [ROWS-1:0]     row_vld_ff;
   logic [ROWS-1:0]     row_ff;
   logic [MEMBER_W-1:0] m_ff [SLOTS];
   logic [SIZE_W-1:0]   size_ff;
   logic [SIZE_W-1:0]   k_ff;

   logic                res_pair_ff;
   logic [MEMBER_W-1:0] res_high_ff;
   logic [MEMBER_W-1:0] res_low_ff;
   logic                res_err_ff;

   logic                rsp_valid_ff;
   logic [REM_W-1:0]    rsp_remaining_ff;
   logic                rsp_pair_ff;
   logic [MEMBER_W-1:0] rsp_high_ff;
   logic [MEMBER_W-1:0] rsp_low_ff;
   logic                rsp_err_ff;

   logic                req_fire;
   logic                rsp_free;
   logic [MEMBER_W-1:0] fields [MEMBER_FIELDS];
   logic [SIZE_W-1:0]   size_in;
   logic [MEMBER_W-1:0] num_in;
   logic [13:0]         pairs_prod;
   logic [MEMBER_W-1:0] cur_member;
   logic [MEMBER_W-1:0] cur_col;
   logic [RW-1:0]       cur_idx;
   logic [RW-1:0]       scan_idx;
   logic [ROWS-1:0]     cur_init;
   logic [ROWS-1:0]     scan_init;
   logic [ROWS-1:0]     cur_word;
   logic [ROWS-1:0]     clear_mask;
   logic [SIZE_W-1:0]   hit_count;
   logic                any_bad;
   logic [SLOTS-1:0]    lane_en;
   logic [SLOTS-1:0]    lane_dup;
   pcot_lane_stat_type  lane_stat [SLOTS];
   logic [ROWS-1:0]     lane_mask [SLOTS];

   logic                ram_rd_en;
   logic [RW-1:0]       ram_rd_addr;
   logic                ram_wr_en;
   logic [ROWS-1:0]     ram_rd_data;

   logic                scan_found;
   logic [OFF_W-1:0]    scan_off;
   logic [CNT_W-1:0]    col_step;
   logic [CNT_W-1:0]    col_hit;
   logic [CNT_W-1:0]    row_plus;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   assign fields[0] = req_chan.member_a;
   assign fields[1] = req_chan.member_b;
   assign fields[2] = req_chan.member_c;
   assign fields[3] = req_chan.member_d;
   assign fields[4] = req_chan.member_e;

   assign size_in = (req_chan.set_size > SIZE_W'(SLOTS)) ? SIZE_W'(SLOTS)
                                                         : req_chan.set_size;

   always_comb begin
      if (csr_write_data < MEMBER_W'(2)) begin
         num_in = MEMBER_W'(2);
      end else if (int'(csr_write_data) > MAX_ITEMS) begin
         num_in = MEMBER_W'(MAX_ITEMS);
      end else begin
         num_in = csr_write_data;
      end
   end

   assign pairs_prod = 14'(num_in) * 14'(num_in - MEMBER_W'(1));

   // Member whose row is being updated in the mark loop.
   always_comb begin
      cur_member = '0;
      for (int j = 0; j < SLOTS; j++) begin
         if (k_ff == SIZE_W'(j)) begin
            cur_member = m_ff[j];
         end
      end
   end

   assign cur_col  = cur_member - MEMBER_W'(1);
   assign cur_idx  = cur_col[RW-1:0];
   assign scan_idx = scan_row_ff[RW-1:0];

   // A row never written holds its reset pattern: ones below the diagonal.
   always_comb begin
      for (int i = 0; i < ROWS; i++) begin
         cur_init[i]  = (RW'(i) < cur_idx);
         scan_init[i] = (RW'(i) < scan_idx);
      end
   end

   assign cur_word = row_vld_ff[cur_idx] ? ram_rd_data : cur_init;

   always_comb begin
      for (int j = 0; j < SLOTS; j++) begin
         lane_en[j]  = (SIZE_W'(j) < size_ff);
         lane_dup[j] = 1'b0;
         for (int p = 0; p < j; p++) begin
            if (m_ff[p] == m_ff[j]) begin
               lane_dup[j] = 1'b1;
            end
         end
      end
   end

   for (genvar g = 0; g < SLOTS; g++) begin : g_lane
      pcot_lane #(
         .ROWS (ROWS)
      ) u_lane (
         .member     (m_ff[g]),
         .enable     (lane_en[g]),
         .dup        (lane_dup[g]),
         .cur_member (cur_member),
         .num_items  (num_ff),
         .row_word   (cur_word),
         .stat       (lane_stat[g]),
         .mask       (lane_mask[g])
      );
   end

   // Merge what the lanes found.
   always_comb begin
      clear_mask = '0;
      hit_count  = '0;
      any_bad    = 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
         clear_mask = clear_mask | lane_mask[j];
         hit_count  = hit_count + SIZE_W'(lane_stat[j].hit);
         any_bad    = any_bad | lane_stat[j].bad;
      end
   end

   pcot_ram #(
      .WIDTH (ROWS),
      .DEPTH (ROWS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cur_idx),
      .wr_data (cur_word & ~clear_mask),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pcot_scan #(
      .ROWS (ROWS)
   ) u_scan (
      .row_word (row_ff),
      .row      (scan_row_ff),
      .col      (scan_col_ff),
      .found    (scan_found),
      .offset   (scan_off)
   );

   assign col_step = scan_col_ff + CNT_W'(CHUNK);
   assign col_hit  = scan_col_ff + CNT_W'(scan_off) + CNT_W'(1);
   assign row_plus = scan_row_ff + CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_chan.mode == MODE_FETCH) ? ST_FETCH_RD : ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = any_bad ? ST_FINISH : ST_MARK_RD;
         end
         ST_MARK_RD: begin
            state_in = (k_ff >= size_ff) ? ST_FINISH : ST_MARK_WR;
         end
         ST_MARK_WR: begin
            state_in = ST_MARK_RD;
         end
         ST_FETCH_RD: begin
            state_in = (scan_row_ff >= CNT_W'(num_ff)) ? ST_FINISH : ST_FETCH_LD;
         end
         ST_FETCH_LD: begin
            state_in = ST_FETCH_SCAN;
         end
         ST_FETCH_SCAN: begin
            if (scan_found) begin
               state_in = ST_FINISH;
            end else if (col_step >= scan_row_ff) begin
               state_in = ST_FETCH_RD;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_chan.ready = 1'b0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = cur_idx;
      ram_wr_en      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         ST_MARK_RD: begin
            ram_rd_en = (k_ff < size_ff);
         end
         ST_MARK_WR: begin
            ram_wr_en = 1'b1;
         end
         ST_FETCH_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = scan_idx;
         end
         ST_CHECK, ST_FETCH_LD, ST_FETCH_SCAN, ST_FINISH: begin
            ram_rd_en = 1'b0;
         end
         default: begin
            ram_rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control state: register value, pair count, cursor, row-valid bits, member index, response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff       <= MEMBER_W'(NUM_RST);
         count_ff     <= REM_W'(CNT_RST);
         scan_row_ff  <= CNT_W'(1);
         scan_col_ff  <= '0;
         row_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         if (csr_write_en) begin
            num_ff      <= num_in;
            count_ff    <= pairs_prod[REM_W:1];
            scan_row_ff <= CNT_W'(1);
            scan_col_ff <= '0;
            row_vld_ff  <= '0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  k_ff <= '0;
               end
            end
            ST_MARK_RD: begin
               if (k_ff >= size_ff) begin
                  scan_row_ff <= CNT_W'(1);
                  scan_col_ff <= '0;
               end
            end
            ST_MARK_WR: begin
               row_vld_ff[cur_idx] <= 1'b1;
               count_ff            <= count_ff - REM_W'(hit_count);
               k_ff                <= k_ff + SIZE_W'(1);
            end
            ST_FETCH_SCAN: begin
               if (scan_found) begin
                  scan_col_ff <= col_hit;
               end else if (col_step >= scan_row_ff) begin
                  scan_row_ff <= row_plus;
                  scan_col_ff <= '0;
               end else begin
                  scan_col_ff <= col_step;
               end
            end
            ST_CHECK, ST_FETCH_RD, ST_FETCH_LD, ST_FINISH: begin
            end
            default: begin
            end
         endcase
         if (state_ff == ST_FINISH && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         size_ff     <= size_in;
         res_pair_ff <= 1'b0;
         res_high_ff <= '0;
         res_low_ff  <= '0;
         res_err_ff  <= 1'b0;
         for (int j = 0; j < SLOTS; j++) begin
            m_ff[j] <= fields[j];
         end
      end
      if (state_ff == ST_CHECK) begin
         res_err_ff <= any_bad;
      end
      if (state_ff == ST_FETCH_LD) begin
         row_ff <= row_vld_ff[scan_idx] ? ram_rd_data : scan_init;
      end
      if (state_ff == ST_FETCH_SCAN && scan_found) begin
         res_pair_ff <= 1'b1;
         res_high_ff <= row_plus[MEMBER_W-1:0];
         res_low_ff  <= col_hit[MEMBER_W-1:0];
      end
      if (state_ff == ST_FINISH && rsp_free) begin
         rsp_remaining_ff <= count_ff;
         rsp_pair_ff      <= res_pair_ff;
         rsp_high_ff      <= res_high_ff;
         rsp_low_ff       <= res_low_ff;
         rsp_err_ff       <= res_err_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.remaining   = rsp_remaining_ff;
   assign rsp_chan.pair_valid  = rsp_pair_ff;
   assign rsp_chan.pair_high   = rsp_high_ff;
   assign rsp_chan.pair_low    = rsp_low_ff;
   assign rsp_chan.range_error = rsp_err_ff;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import pcot_pkg::*;

   localparam int ITEM_CAP    = 64;
   localparam int SLOT_CAP    = 5;
   localparam int IDLE_PCT    = 22;
   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN       = 500;
   localparam int PHASE_WORDS = 48;

   typedef struct packed {
      logic                                     mode;
      logic [SIZE_W-1:0]                        set_size;
      logic [MEMBER_FIELDS-1:0][MEMBER_W-1:0]   member;
   } req_word_type;

   localparam int REQ_W = $bits(req_word_type);

   typedef struct packed {
      logic [REM_W-1:0]    remaining;
      logic                pair_valid;
      logic [MEMBER_W-1:0] pair_high;
      logic [MEMBER_W-1:0] pair_low;
      logic                range_error;
   } tally_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type        kind;
      logic [MEMBER_W-1:0] cfg_value;
      req_word_type        word;
      bit                  typed;
      tally_type           want;
   } plan_row_type;

   logic                clock;
   logic                reset;
   logic                csr_write_en;
   logic [MEMBER_W-1:0] csr_write_data;

   pcot_req_if req_bus ();
   pcot_rsp_if rsp_bus ();

   pair_cooccurrence_tracker_top #(
      .MAX_ITEMS (ITEM_CAP),
      .SET_SLOTS (SLOT_CAP)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // Shadow copy of the pair bitmap: open_pairs[row][col] is set while the
   // pair (row+1, col+1) has not been seen together.
   bit [ITEM_CAP-1:0] open_pairs [ITEM_CAP];
   int unsigned       open_count;
   int unsigned       scan_row;
   int unsigned       scan_col;
   int unsigned       item_limit;

   tally_type         tally_due [$];
   plan_row_type      plan [$];
   int unsigned       mismatch_count;
   int unsigned       quiet_cycles;
   bit                steady;
   tally_type         seen;
   tally_type         oldest;

   always #6 clock = ~clock;

   function automatic void reload_pairs(input logic [MEMBER_W-1:0] value);
      int unsigned       r;
      bit [ITEM_CAP-1:0] one_bit;
      one_bit    = 1;
      item_limit = (value < 2) ? 2 : ((value > ITEM_CAP) ? ITEM_CAP : value);
      for (r = 0; r < ITEM_CAP; r++) begin
         open_pairs[r] = (r < item_limit) ? ((one_bit << r) - 1'b1) : '0;
      end
      open_count = item_limit * (item_limit - 1) / 2;
      scan_row   = 1;
      scan_col   = 0;
   endfunction

   function automatic tally_type cover_word(input req_word_type w);
      tally_type   t;
      int unsigned used;
      int unsigned i;
      int unsigned j;
      int unsigned hi;
      int unsigned lo;
      bit          bad;
      t   = '0;
      bad = 1'b0;
      if (w.mode == MODE_MARK) begin
         used = (w.set_size > SLOT_CAP) ? SLOT_CAP : w.set_size;
         for (i = 0; i < used; i++) begin
            if (w.member[i] < 1 || w.member[i] > item_limit) bad = 1'b1;
         end
         if (!bad) begin
            for (i = 0; i + 1 < used; i++) begin
               for (j = i + 1; j < used; j++) begin
                  if (w.member[i] != w.member[j]) begin
                     hi = (w.member[i] > w.member[j]) ? w.member[i] : w.member[j];
                     lo = (w.member[i] > w.member[j]) ? w.member[j] : w.member[i];
                     if (open_pairs[hi-1][lo-1]) begin
                        open_pairs[hi-1][lo-1] = 1'b0;
                        open_count--;
                     end
                  end
               end
            end
            scan_row = 1;
            scan_col = 0;
         end
         t.range_error = bad;
      end else begin
         while (scan_row < item_limit && !t.pair_valid) begin
            if (scan_col >= scan_row) begin
               scan_row++;
               scan_col = 0;
            end else begin
               if (open_pairs[scan_row][scan_col]) begin
                  t.pair_valid = 1'b1;
                  t.pair_high  = MEMBER_W'(scan_row + 1);
                  t.pair_low   = MEMBER_W'(scan_col + 1);
               end
               scan_col++;
            end
         end
      end
      t.remaining = open_count[REM_W-1:0];
      return t;
   endfunction

   function automatic void put_fetch(input bit typed, input int rem, input bit pv,
                                     input int ph, input int pl);
      plan_row_type row;
      row.kind      = ROW_WORD;
      row.cfg_value = '0;
      row.word      = '0;
      row.word.mode = MODE_FETCH;
      row.typed     = typed;
      row.want      = '{REM_W'(rem), pv, MEMBER_W'(ph), MEMBER_W'(pl), 1'b0};
      plan.push_back(row);
   endfunction

   function automatic void put_mark(input int size, input int a, input int b, input int c,
                                    input int d, input int e, input bit typed, input int rem,
                                    input bit err);
      plan_row_type row;
      row.kind          = ROW_WORD;
      row.cfg_value     = '0;
      row.word          = '0;
      row.word.mode     = MODE_MARK;
      row.word.set_size = SIZE_W'(size);
      row.word.member   = {e[MEMBER_W-1:0], d[MEMBER_W-1:0], c[MEMBER_W-1:0],
                           b[MEMBER_W-1:0], a[MEMBER_W-1:0]};
      row.typed         = typed;
      row.want          = '{REM_W'(rem), 1'b0, 7'd0, 7'd0, err};
      plan.push_back(row);
   endfunction

   function automatic void put_csr(input int value);
      plan_row_type row;
      row.kind      = ROW_CSR;
      row.cfg_value = MEMBER_W'(value);
      row.word      = '0;
      row.typed     = 1'b0;
      row.want      = '0;
      plan.push_back(row);
   endfunction

   function automatic req_word_type make_word();
      req_word_type w;
      int unsigned  pick;
      int unsigned  i;
      w    = REQ_W'({$urandom, $urandom});
      pick = $urandom_range(99);
      if (pick < 45) begin
         w.mode = MODE_FETCH;
      end else begin
         w.mode = MODE_MARK;
         if (pick < 90) begin
            // Well-formed set: every used member is in range.
            w.set_size = ($urandom_range(9) == 0) ? SIZE_W'($urandom_range(7))
                                                  : SIZE_W'($urandom_range(2, 5));
            for (i = 0; i < MEMBER_FIELDS; i++) begin
               if (i < w.set_size) w.member[i] = MEMBER_W'($urandom_range(1, item_limit));
            end
         end
      end
      return w;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Called just after a falling edge; returns just after the falling edge that follows acceptance.
   task automatic send_word(input req_word_type w, input bit typed, input tally_type want);
      tally_type predicted;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.mode     <= w.mode;
      req_bus.set_size <= w.set_size;
      req_bus.member_a <= w.member[0];
      req_bus.member_b <= w.member[1];
      req_bus.member_c <= w.member[2];
      req_bus.member_d <= w.member[3];
      req_bus.member_e <= w.member[4];
      req_bus.valid    <= 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = cover_word(w);
      tally_due.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic write_item_count(input logic [MEMBER_W-1:0] value);
      req_bus.valid <= 1'b0;
      while (tally_due.size() != 0) @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      reload_pairs(value);
   endtask

   always @(negedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen = '{rsp_bus.remaining, rsp_bus.pair_valid, rsp_bus.pair_high,
                  rsp_bus.pair_low, rsp_bus.range_error};
         if (tally_due.size() == 0) begin
            report_mismatch("unexpected word, remaining", seen.remaining, 0);
         end else begin
            oldest = tally_due.pop_front();
            if (seen.remaining !== oldest.remaining)
               report_mismatch("remaining", seen.remaining, oldest.remaining);
            if (seen.pair_valid !== oldest.pair_valid)
               report_mismatch("pair_valid", seen.pair_valid, oldest.pair_valid);
            if (seen.pair_high !== oldest.pair_high)
               report_mismatch("pair_high", seen.pair_high, oldest.pair_high);
            if (seen.pair_low !== oldest.pair_low)
               report_mismatch("pair_low", seen.pair_low, oldest.pair_low);
            if (seen.range_error !== oldest.range_error)
               report_mismatch("range_error", seen.range_error, oldest.range_error);
         end
      end
   end

   // The longest fetch walks every row once.
   always @(posedge clock) begin
      if (reset || csr_write_en || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned phase_cfg [10];
      int unsigned p;
      int unsigned k;
      tally_type   none;
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_en     = 1'b0;
      csr_write_data   = '0;
      req_bus.valid    = 1'b0;
      req_bus.mode     = MODE_MARK;
      req_bus.set_size = '0;
      req_bus.member_a = '0;
      req_bus.member_b = '0;
      req_bus.member_c = '0;
      req_bus.member_d = '0;
      req_bus.member_e = '0;
      rsp_bus.ready    = 1'b0;
      mismatch_count   = 0;
      quiet_cycles     = 0;
      steady           = 1'b0;
      none             = '0;
      phase_cfg        = '{5, 2, 3, 127, 1, 8, 12, 30, 64, 4};
      reload_pairs(7'd64);

      // Directed part, starting from the reset count of 64 items.
      put_fetch(1, 2016, 1, 2, 1);
      put_fetch(1, 2016, 1, 3, 1);
      put_fetch(1, 2016, 1, 3, 2);
      put_mark(2, 64, 1, 0, 0, 0, 1, 2015, 0);
      put_mark(2, 1, 64, 0, 0, 0, 1, 2015, 0);
      put_mark(2, 0, 5, 0, 0, 0, 1, 2015, 1);
      put_mark(2, 65, 5, 0, 0, 0, 1, 2015, 1);
      put_mark(3, 127, 0, 9, 0, 0, 1, 2015, 1);
      put_mark(5, 7, 7, 7, 7, 7, 1, 2015, 0);
      put_mark(0, 127, 127, 127, 127, 127, 1, 2015, 0);
      put_mark(1, 0, 127, 127, 127, 127, 1, 2015, 1);
      put_mark(1, 1, 0, 0, 0, 0, 1, 2015, 0);
      // An oversized set keeps only the five member slots.
      put_mark(7, 1, 2, 3, 4, 5, 1, 2005, 0);
      put_fetch(1, 2005, 1, 6, 1);
      put_mark(6, 2, 3, 9, 10, 127, 1, 2005, 1);
      put_mark(4, 10, 20, 30, 40, 127, 0, 0, 0);
      put_mark(5, 64, 63, 1, 2, 64, 0, 0, 0);
      put_fetch(0, 0, 0, 0, 0);
      put_csr(0);
      put_fetch(1, 1, 1, 2, 1);
      put_fetch(1, 1, 0, 0, 0);
      put_fetch(1, 1, 0, 0, 0);
      put_mark(2, 2, 3, 0, 0, 0, 1, 1, 1);
      put_mark(2, 2, 1, 0, 0, 0, 1, 0, 0);
      put_fetch(1, 0, 0, 0, 0);
      put_csr(127);
      put_fetch(1, 2016, 1, 2, 1);

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (k = 0; k < plan.size(); k++) begin
         if (plan[k].kind == ROW_CSR) write_item_count(plan[k].cfg_value);
         else send_word(plan[k].word, plan[k].typed, plan[k].want);
      end

      for (p = 0; p < 10; p++) begin
         write_item_count(MEMBER_W'((p == 7) ? $urandom_range(2, ITEM_CAP) : phase_cfg[p]));
         // One phase runs with both sides always ready.
         steady = (p == 3);
         for (k = 0; k < PHASE_WORDS; k++) send_word(make_word(), 1'b0, none);
      end
      steady = 1'b0;

      req_bus.valid <= 1'b0;
      while (tally_due.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (tally_due.size() != 0) report_mismatch("missing words", tally_due.size(), 0);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/pcot_pkg.sv
rtl/core/pcot_req_if.sv
rtl/core/pcot_rsp_if.sv
rtl/core/pcot_ram.sv
rtl/core/pcot_lane.sv
rtl/core/pcot_scan.sv
rtl/core/pair_cooccurrence_tracker_top.sv
sim/testbench.sv
